/* rtl/core/obsd_pkg.sv */
`default_nettype none

package obsd_pkg;

	localparam int LEVELS     = 64;
	localparam int PRICE_BITS = 32;
	localparam int QTY_BITS   = 32;

	localparam int IDX_BITS = $clog2(LEVELS);
	localparam int CNT_BITS = $clog2(LEVELS + 1);
	// threshold minus running total: LEVELS quantities down, one own order up
	localparam int SUM_BITS = QTY_BITS + CNT_BITS + 2;

	// port field widths
	localparam int OUT_PRICE_BITS = 32;
	localparam int IN_DATA_BITS   = ((2 * PRICE_BITS + 2 * QTY_BITS + 7) / 8) * 8;
	localparam int IN_USER_BITS   = 8;
	localparam int OUT_DATA_BITS  = OUT_PRICE_BITS;
	localparam int OUT_USER_BITS  = 8;

	typedef enum logic [1:0] {
		ACT_NEW    = 2'd0,
		ACT_CHANGE = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2,
		STS_DUP       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_TAIL = 2'd2,
		S_DONE = 2'd3
	} state_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
	} level_t;

endpackage

`default_nettype wire

/* rtl/core/obsd_ram.sv */
`default_nettype none

module obsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/order_book_side_depth.sv */
// One side of an order book: up to LEVELS price levels kept sorted by price
// in a single level RAM, walked by a small sequencer with one shared compare
// and add unit.
// Input channel s_axis: one word per request. tuser[1:0] is the action
// (new, change, delete, depth query), tuser[2] flags an own order for a query.
// Output channel m_axis: exactly one word per request with the status, the
// found flag and the depth price.
// cfg_we/cfg_wdata set the side: 0 ascending (asks), 1 descending (bids).
// Changing the side empties the book; write it only while the block is idle.
// Every request walks the held levels once, one level per cycle, through the
// RAM read port, while shifts for insert and delete go out on the write port
// in the same pass. Change, duplicate new and a query that meets its threshold
// end the walk early. s_axis_tready is high only while no request is in work,
// so requests are taken one at a time.
// The result sits in an output register: a stalled receiver does not block the
// next request, but the following result waits until that register drains.
// Reset empties the book, selects ascending order and drops any result.
`default_nettype none

module order_book_side_depth (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// price, quantity, own_price, own_quantity
	input  wire logic [obsd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
	// action[1:0], own_present[2], zeros
	input  wire logic [obsd_pkg::IN_USER_BITS-1:0]   s_axis_tuser,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// depth_price
	output logic      [obsd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	// status[1:0], found[2], zeros
	output logic      [obsd_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata
);

	localparam int PB = obsd_pkg::PRICE_BITS;
	localparam int QB = obsd_pkg::QTY_BITS;
	localparam int IB = obsd_pkg::IDX_BITS;
	localparam int CB = obsd_pkg::CNT_BITS;
	localparam int SB = obsd_pkg::SUM_BITS;

	obsd_pkg::state_t  state_q, state_nxt;
	logic              desc_q;
	logic [CB-1:0]     count_q;
	logic              out_vld_q;
	logic [1:0]        out_status_q;
	logic              out_found_q;
	logic [PB-1:0]     out_depth_q;

	obsd_pkg::action_t act_q;
	logic [PB-1:0]     price_q;
	logic [QB-1:0]     qty_q;
	logic              own_q;
	logic [PB-1:0]     own_price_q;
	logic [QB-1:0]     own_qty_q;

	logic [CB-1:0]     rd_idx_q;
	logic              proc_vld_q;
	logic [IB-1:0]     proc_idx_q;
	logic              ins_q;
	logic              hit_q;
	obsd_pkg::level_t  carry_q;
	logic [SB-1:0]     slack_q;

	obsd_pkg::status_t res_status_q;
	logic              res_found_q;
	logic [PB-1:0]     res_depth_q;

	obsd_pkg::level_t  rdata;
	logic              in_acc;
	logic              out_free;
	logic              cnt_full;
	logic [PB-1:0]     cmp_price;
	logic              eq;
	logic              sorts_first;
	logic              own_hit;
	logic [SB-1:0]     slack_nxt;

	logic              issue;
	logic              we;
	logic [IB-1:0]     waddr;
	obsd_pkg::level_t  wdata;
	logic              stop;
	logic              res_load;
	obsd_pkg::status_t res_status;
	logic              res_found;

	assign s_axis_tready = (state_q == obsd_pkg::S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign cnt_full      = (count_q == CB'(obsd_pkg::LEVELS));

	// shared compare and add unit
	assign cmp_price   = (act_q == obsd_pkg::ACT_QUERY) ? own_price_q : price_q;
	assign eq          = (rdata.price == cmp_price);
	assign sorts_first = desc_q ? (price_q > rdata.price) : (price_q < rdata.price);
	assign own_hit     = own_q && eq;
	assign slack_nxt   = slack_q - SB'(rdata.qty) + (own_hit ? SB'(own_qty_q) : SB'(0));

	obsd_ram #(
		.WIDTH($bits(obsd_pkg::level_t)),
		.DEPTH(obsd_pkg::LEVELS)
	) u_levels (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue),
		.raddr(rd_idx_q[IB-1:0]),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			obsd_pkg::S_IDLE: begin
				if (in_acc) begin
					state_nxt = obsd_pkg::S_SCAN;
				end
			end
			obsd_pkg::S_SCAN: begin
				if (stop) begin
					state_nxt = obsd_pkg::S_DONE;
				end else if (!proc_vld_q && (rd_idx_q == count_q)) begin
					state_nxt = obsd_pkg::S_TAIL;
				end
			end
			obsd_pkg::S_TAIL: begin
				state_nxt = obsd_pkg::S_DONE;
			end
			obsd_pkg::S_DONE: begin
				if (out_free) begin
					state_nxt = obsd_pkg::S_IDLE;
				end
			end
			default: state_nxt = obsd_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		issue      = 1'b0;
		we         = 1'b0;
		waddr      = proc_idx_q;
		wdata      = carry_q;
		stop       = 1'b0;
		res_load   = 1'b0;
		res_status = obsd_pkg::STS_OK;
		res_found  = 1'b0;
		case (state_q)
			obsd_pkg::S_SCAN: begin
				issue = (rd_idx_q < count_q);
				if (proc_vld_q) begin
					case (act_q)
						obsd_pkg::ACT_NEW: begin
							if (eq) begin
								stop       = 1'b1;
								res_status = obsd_pkg::STS_DUP;
							end else if (!cnt_full && (ins_q || sorts_first)) begin
								// drop the carried level here, pick up the old one
								we = 1'b1;
							end
						end
						obsd_pkg::ACT_CHANGE: begin
							if (eq) begin
								stop        = 1'b1;
								we          = 1'b1;
								wdata.price = rdata.price;
								wdata.qty   = qty_q;
							end
						end
						obsd_pkg::ACT_DELETE: begin
							if (hit_q) begin
								// pull each later level up by one
								we    = 1'b1;
								waddr = proc_idx_q - 1'b1;
								wdata = rdata;
							end
						end
						obsd_pkg::ACT_QUERY: begin
							if (slack_nxt[SB-1]) begin
								stop      = 1'b1;
								res_found = 1'b1;
							end
						end
						default: ;
					endcase
				end
				res_load = stop;
			end
			obsd_pkg::S_TAIL: begin
				res_load = 1'b1;
				case (act_q)
					obsd_pkg::ACT_NEW: begin
						if (cnt_full) begin
							res_status = obsd_pkg::STS_FULL;
						end else begin
							we    = 1'b1;
							waddr = count_q[IB-1:0];
						end
					end
					obsd_pkg::ACT_CHANGE: res_status = obsd_pkg::STS_NOT_FOUND;
					obsd_pkg::ACT_DELETE: begin
						if (!hit_q) begin
							res_status = obsd_pkg::STS_NOT_FOUND;
						end
					end
					default: res_status = obsd_pkg::STS_OK;
				endcase
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= obsd_pkg::S_IDLE;
			desc_q     <= 1'b0;
			count_q    <= '0;
			out_vld_q  <= 1'b0;
			proc_vld_q <= 1'b0;
			rd_idx_q   <= '0;
			ins_q      <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				rd_idx_q   <= '0;
				proc_vld_q <= 1'b0;
				ins_q      <= 1'b0;
				hit_q      <= 1'b0;
			end else if (state_q == obsd_pkg::S_SCAN) begin
				proc_vld_q <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (proc_vld_q && (act_q == obsd_pkg::ACT_NEW) && we) begin
					ins_q <= 1'b1;
				end
				if (proc_vld_q && eq) begin
					hit_q <= 1'b1;
				end
			end
			if (state_q == obsd_pkg::S_TAIL) begin
				if ((act_q == obsd_pkg::ACT_NEW) && !cnt_full) begin
					count_q <= count_q + 1'b1;
				end else if ((act_q == obsd_pkg::ACT_DELETE) && hit_q) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (cfg_we && (cfg_wdata != desc_q)) begin
				desc_q  <= cfg_wdata;
				count_q <= '0;
			end
			if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if ((state_q == obsd_pkg::S_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q         <= obsd_pkg::action_t'(s_axis_tuser[1:0]);
			own_q         <= s_axis_tuser[2];
			price_q       <= s_axis_tdata[PB-1:0];
			qty_q         <= s_axis_tdata[PB +: QB];
			own_price_q   <= s_axis_tdata[PB + QB +: PB];
			own_qty_q     <= s_axis_tdata[2 * PB + QB +: QB];
			carry_q.price <= s_axis_tdata[PB-1:0];
			carry_q.qty   <= s_axis_tdata[PB +: QB];
			slack_q       <= SB'(s_axis_tdata[PB +: QB]);
		end else if ((state_q == obsd_pkg::S_SCAN) && proc_vld_q) begin
			slack_q <= slack_nxt;
			if ((act_q == obsd_pkg::ACT_NEW) && we) begin
				carry_q <= rdata;
			end
		end
		if (state_q == obsd_pkg::S_SCAN) begin
			proc_idx_q <= rd_idx_q[IB-1:0];
		end
		if (res_load) begin
			res_status_q <= res_status;
			res_found_q  <= res_found;
			res_depth_q  <= res_found ? rdata.price : '0;
		end
		if ((state_q == obsd_pkg::S_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_depth_q  <= res_depth_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = obsd_pkg::OUT_DATA_BITS'(out_depth_q);
	assign m_axis_tuser  = obsd_pkg::OUT_USER_BITS'({out_found_q, out_status_q});

endmodule

`default_nettype wire
